// ===== rtl/block_owner_map_allocator_assert.svh =====
// assertion macros shared by the block owner map allocator
`ifndef BLOCK_OWNER_MAP_ALLOCATOR_ASSERT_SVH
`define BLOCK_OWNER_MAP_ALLOCATOR_ASSERT_SVH

// same-cycle implication, checked out of reset
`define BOM_ASSERT_IMP(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error("bom assertion failed");

// next-cycle implication, checked out of reset
`define BOM_ASSERT_NEXT(lbl, pre, post) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error("bom assertion failed");

`endif

// ===== rtl/bom_pkg.sv =====
// types and constants of the block owner map allocator
package bom_pkg;

	// default sizes
	localparam int MEM_BLOCKS_DEF       = 1024;
	localparam int RT_REGION_BLOCKS_DEF = 64;
	localparam int OWNER_WIDTH_DEF      = 16;

	// fixed field widths
	localparam int OWNER_IN_W = 16;
	localparam int START_W    = 10;
	localparam int COUNT_W    = 11;
	localparam int STATUS_W   = 3;
	localparam int CONFLICT_W = 10;

	// command codes
	localparam logic CMD_ALLOC = 1'b0;
	localparam logic CMD_FREE  = 1'b1;

	// result status codes
	typedef enum logic [STATUS_W-1:0] {
		ST_ALLOCATED = 3'd0,
		ST_FULL      = 3'd1,
		ST_OCCUPIED  = 3'd2,
		ST_FREED     = 3'd3,
		ST_RANGE     = 3'd4
	} status_t;

	// request from the front end to the map sequencer
	typedef struct packed {
		logic go;
		logic is_free;
		logic ack;
	} seq_req_t;

	// response from the map sequencer
	typedef struct packed {
		logic                  idle;
		logic                  done;
		logic                  occupied;
		logic [CONFLICT_W-1:0] conflict;
	} seq_rsp_t;

endpackage

// ===== rtl/bom_ram.sv =====
// generic simple dual-port ram with registered read
module bom_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port and registered read port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/bom_seq.sv =====
// map sequencer: clearing pass, span check, span write and span free over the owner map
module bom_seq import bom_pkg::*; #(
	parameter int MEM_BLOCKS  = MEM_BLOCKS_DEF,
	parameter int OWNER_WIDTH = OWNER_WIDTH_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  seq_req_t               req,
	input  logic [OWNER_WIDTH-1:0] owner,
	input  logic [START_W-1:0]     start_blk,
	input  logic [COUNT_W-1:0]     count,
	output seq_rsp_t               rsp
);

	localparam int AW = $clog2(MEM_BLOCKS);

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_CHECK,
		S_WRITE,
		S_FREE,
		S_DONE
	} state_t;

	state_t                  state_q;
	logic [AW-1:0]           addr_q;
	logic [COUNT_W-1:0]      left_q;
	logic                    rd_vld_s1;
	logic [AW-1:0]           rd_addr_s1;
	logic                    occ_q;
	logic [CONFLICT_W-1:0]   conflict_q;

	logic                    we;
	logic [AW-1:0]           waddr;
	logic [OWNER_WIDTH-1:0]  wdata;
	logic [OWNER_WIDTH-1:0]  rdata;
	logic [31:0]             start_ext;
	logic [AW-1:0]           start_a;
	logic [31:0]             rd_addr_ext;
	logic                    issue;
	logic                    hit_taken;
	logic                    hit_owner;

	// span start and conflict index at the map and port widths
	assign start_ext   = 32'(start_blk);
	assign start_a     = start_ext[AW-1:0];
	assign rd_addr_ext = 32'(rd_addr_s1);

	assign issue     = (left_q != '0);
	assign hit_taken = rd_vld_s1 && (rdata != '0);
	assign hit_owner = rd_vld_s1 && (rdata == owner);

	// map write port: clearing, span write, or write-back of a freed entry
	always_comb begin
		we    = 1'b0;
		waddr = addr_q;
		wdata = '0;
		case (state_q)
			S_CLEAR: begin
				we = 1'b1;
			end
			S_WRITE: begin
				we    = issue;
				wdata = owner;
			end
			S_FREE: begin
				we    = hit_owner;
				waddr = rd_addr_s1;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	bom_ram #(
		.WIDTH (OWNER_WIDTH),
		.DEPTH (MEM_BLOCKS)
	) u_map (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (addr_q),
		.rdata (rdata)
	);

	// sequencer state and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= S_CLEAR;
			addr_q     <= '0;
			left_q     <= '0;
			rd_vld_s1  <= 1'b0;
			rd_addr_s1 <= '0;
			occ_q      <= 1'b0;
			conflict_q <= '0;
		end else begin
			case (state_q)
				S_CLEAR: begin
					addr_q <= addr_q + 1'b1;
					if (addr_q == AW'(MEM_BLOCKS - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					rd_vld_s1 <= 1'b0;
					if (req.go) begin
						addr_q  <= start_a;
						left_q  <= count;
						occ_q   <= 1'b0;
						state_q <= req.is_free ? S_FREE : S_CHECK;
					end
				end
				S_CHECK: begin
					// one read per cycle, data compared in the cycle after the read
					if (issue) begin
						addr_q     <= addr_q + 1'b1;
						left_q     <= left_q - 1'b1;
						rd_addr_s1 <= addr_q;
					end
					rd_vld_s1 <= issue;
					if (hit_taken) begin
						occ_q      <= 1'b1;
						conflict_q <= rd_addr_ext[CONFLICT_W-1:0];
						state_q    <= S_DONE;
					end else if (!issue && !rd_vld_s1) begin
						addr_q  <= start_a;
						left_q  <= count;
						state_q <= S_WRITE;
					end
				end
				S_WRITE: begin
					if (issue) begin
						addr_q <= addr_q + 1'b1;
						left_q <= left_q - 1'b1;
					end else begin
						state_q <= S_DONE;
					end
				end
				S_FREE: begin
					// read ahead while the previous entry is written back
					if (issue) begin
						addr_q     <= addr_q + 1'b1;
						left_q     <= left_q - 1'b1;
						rd_addr_s1 <= addr_q;
					end
					rd_vld_s1 <= issue;
					if (!issue && !rd_vld_s1) begin
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					rd_vld_s1 <= 1'b0;
					if (req.ack) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign rsp.idle     = (state_q == S_IDLE);
	assign rsp.done     = (state_q == S_DONE);
	assign rsp.occupied = occ_q;
	assign rsp.conflict = conflict_q;

endmodule

// ===== rtl/block_owner_map_allocator.sv =====
// a full-region or out-of-range request goes straight to the output register; an allocate reads
// every span entry, then writes the span, and stops at the first taken block; a free reads
// each span entry and clears those held by its owner; a count of 0 still goes to the sequencer.
// throughput: one transaction at a time, the next taken once the sequencer is idle and the
// result register is empty or being read; immediate results can follow back to back.
// after reset the map is cleared one entry a cycle, stall held high.
module block_owner_map_allocator import bom_pkg::*; #(
	parameter int MEM_BLOCKS       = MEM_BLOCKS_DEF,
	parameter int RT_REGION_BLOCKS = RT_REGION_BLOCKS_DEF,
	parameter int OWNER_WIDTH      = OWNER_WIDTH_DEF
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic                  command,
	input  logic                  realtime_class,
	input  logic [OWNER_IN_W-1:0] owner_id,
	input  logic [START_W-1:0]    start_block,
	input  logic [COUNT_W-1:0]    block_count,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [STATUS_W-1:0]   status,
	output logic [CONFLICT_W-1:0] conflict_block
);

	localparam int MARK_W = $clog2(MEM_BLOCKS + 1);

	logic                   busy_q;
	logic                   go_q;
	logic                   cmd_q;
	logic                   rt_q;
	logic [OWNER_WIDTH-1:0] owner_q;
	logic [START_W-1:0]     start_blk_q;
	logic [COUNT_W-1:0]     count_q;
	logic [MARK_W-1:0]      rt_marker_q;
	logic [MARK_W-1:0]      user_marker_q;
	logic                   res_vld_q;
	status_t                status_q;
	logic [CONFLICT_W-1:0]  conflict_q;

	seq_req_t               seq_req;
	seq_rsp_t               seq_rsp;
	logic                   in_accept;
	logic                   res_free;
	logic [COUNT_W:0]       end_in;
	logic [COUNT_W-1:0]     end_q;
	logic [31:0]            end_q_ext;
	logic [31:0]            owner_ext;
	logic                   range_bad;
	logic                   region_full;
	logic                   immediate;
	status_t                imm_status;
	logic                   seq_finish;

	// handshake
	assign res_free  = !res_vld_q || !out_stall;
	assign in_stall  = busy_q || !seq_rsp.idle || !res_free;
	assign in_accept = in_valid && !in_stall;

	// up-front checks: region full, then span past the map
	assign end_in      = {2'b00, start_block} + {1'b0, block_count};
	assign range_bad   = 32'(end_in) > 32'(MEM_BLOCKS);
	assign region_full = realtime_class
		? (32'(rt_marker_q) == 32'(RT_REGION_BLOCKS))
		: (32'(user_marker_q) == 32'(MEM_BLOCKS));
	assign immediate   = ((command == CMD_ALLOC) && region_full) || range_bad;
	assign imm_status  = ((command == CMD_ALLOC) && region_full) ? ST_FULL : ST_RANGE;

	assign owner_ext = 32'(owner_id);
	assign end_q     = {1'b0, start_blk_q} + count_q;
	assign end_q_ext = 32'(end_q);

	assign seq_finish = seq_rsp.done && res_free;

	assign seq_req.go      = go_q;
	assign seq_req.is_free = (cmd_q == CMD_FREE);
	assign seq_req.ack     = res_free;

	// captured transaction, held stable while the sequencer works on it
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q       <= command;
			rt_q        <= realtime_class;
			owner_q     <= owner_ext[OWNER_WIDTH-1:0];
			start_blk_q <= start_block;
			count_q     <= block_count;
		end
	end

	// busy flag, sequencer kick-off and end markers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q        <= 1'b0;
			go_q          <= 1'b0;
			rt_marker_q   <= '0;
			user_marker_q <= '0;
		end else begin
			go_q <= in_accept && !immediate;
			if (in_accept && !immediate) begin
				busy_q <= 1'b1;
			end else if (seq_finish) begin
				busy_q <= 1'b0;
			end
			if (seq_finish) begin
				if (cmd_q == CMD_FREE) begin
					rt_marker_q <= '0;
				end else if (!seq_rsp.occupied) begin
					if (rt_q) begin
						rt_marker_q <= end_q_ext[MARK_W-1:0];
					end else begin
						user_marker_q <= end_q_ext[MARK_W-1:0];
					end
				end
			end
		end
	end

	bom_seq #(
		.MEM_BLOCKS  (MEM_BLOCKS),
		.OWNER_WIDTH (OWNER_WIDTH)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (seq_req),
		.owner     (owner_q),
		.start_blk (start_blk_q),
		.count     (count_q),
		.rsp       (seq_rsp)
	);

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_vld_q <= 1'b0;
		end else if (seq_finish) begin
			res_vld_q <= 1'b1;
		end else if (in_accept && immediate) begin
			res_vld_q <= 1'b1;
		end else if (!out_stall) begin
			res_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (seq_finish) begin
			if (cmd_q == CMD_FREE) begin
				status_q   <= ST_FREED;
				conflict_q <= '0;
			end else if (seq_rsp.occupied) begin
				status_q   <= ST_OCCUPIED;
				conflict_q <= seq_rsp.conflict;
			end else begin
				status_q   <= ST_ALLOCATED;
				conflict_q <= '0;
			end
		end else if (in_accept && immediate) begin
			status_q   <= imm_status;
			conflict_q <= '0;
		end
	end

	assign out_valid      = res_vld_q;
	assign status         = status_q;
	assign conflict_block = conflict_q;

	`include "block_owner_map_allocator_assert.svh"

	`BOM_ASSERT_IMP(a_done_only_busy, seq_rsp.done, busy_q)
	`BOM_ASSERT_NEXT(a_go_leaves_idle, go_q, !seq_rsp.idle)
	`BOM_ASSERT_IMP(a_conflict_zero, res_vld_q && (status_q != ST_OCCUPIED), conflict_q == '0)
	`BOM_ASSERT_IMP(a_marker_bound, 1'b1, 32'(user_marker_q) <= 32'(MEM_BLOCKS))

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for the block owner map allocator: directed table, random traffic, then a closing fill
`timescale 1ns / 100ps

module tb_top import bom_pkg::*; ();

	// class codes
	localparam logic CLASS_RT   = 1'b1;
	localparam logic CLASS_USER = 1'b0;

	localparam int MAP_SIZE     = MEM_BLOCKS_DEF;
	localparam int MAP_AW       = $clog2(MAP_SIZE);
	localparam int RT_SIZE      = RT_REGION_BLOCKS_DEF;
	localparam int RANDOM_ITEMS = 260;
	localparam int REPORT_LIMIT = 10;

	typedef struct {
		logic                  cmd;
		logic                  rt;
		logic [OWNER_IN_W-1:0] owner;
		logic [START_W-1:0]    start;
		logic [COUNT_W-1:0]    count;
	} request_t;

	typedef struct {
		status_t               st;
		logic [CONFLICT_W-1:0] cf;
	} result_t;

	typedef struct {
		request_t rq;
		bit       typed;
		result_t  res;
	} table_row_t;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  in_valid = 1'b0;
	logic                  in_stall;
	logic                  command = 1'b0;
	logic                  realtime_class = 1'b0;
	logic [OWNER_IN_W-1:0] owner_id = '0;
	logic [START_W-1:0]    start_block = '0;
	logic [COUNT_W-1:0]    block_count = '0;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [STATUS_W-1:0]   status;
	logic [CONFLICT_W-1:0] conflict_block;

	// shadow copy of the block state
	logic [OWNER_WIDTH_DEF-1:0] shadow_map [MAP_SIZE];
	logic [COUNT_W-1:0]         shadow_rt_end;
	logic [COUNT_W-1:0]         shadow_user_end;

	result_t    pending_results [$];
	table_row_t directed_reqs [$];
	request_t   live_spans [$];
	logic [OWNER_IN_W-1:0] owner_pool [8];

	int fail_count = 0;
	int burst_left = 0;
	int stall_run = 0;

	block_owner_map_allocator u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.command       (command),
		.realtime_class(realtime_class),
		.owner_id      (owner_id),
		.start_block   (start_block),
		.block_count   (block_count),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.conflict_block(conflict_block)
	);

	// clock
	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	// work out the result of one request and update the shadow state
	task automatic predict_map_update(input request_t rq, output result_t res);
		int  first;
		int  last;
		int  idx;
		bit  hit;
		int  cur_end;
		int  full_end;
		first = int'(rq.start);
		last = first + int'(rq.count);
		res.st = ST_ALLOCATED;
		res.cf = '0;
		hit = 1'b0;
		if (rq.cmd == CMD_ALLOC) begin
			cur_end = rq.rt ? int'(shadow_rt_end) : int'(shadow_user_end);
			full_end = rq.rt ? RT_SIZE : MAP_SIZE;
			if (cur_end == full_end) begin
				res.st = ST_FULL;
			end else if (last > MAP_SIZE) begin
				res.st = ST_RANGE;
			end else begin
				// whole span is checked before anything is written
				for (idx = first; idx < last && !hit; idx++) begin
					if (shadow_map[MAP_AW'(idx)] != '0) begin
						hit = 1'b1;
						res.st = ST_OCCUPIED;
						res.cf = idx[CONFLICT_W-1:0];
					end
				end
				if (!hit) begin
					for (idx = first; idx < last; idx++)
						shadow_map[MAP_AW'(idx)] = rq.owner[OWNER_WIDTH_DEF-1:0];
					if (rq.rt)
						shadow_rt_end = last[COUNT_W-1:0];
					else
						shadow_user_end = last[COUNT_W-1:0];
				end
			end
		end else begin
			if (last > MAP_SIZE) begin
				res.st = ST_RANGE;
			end else begin
				// only blocks held by this owner are released
				for (idx = first; idx < last; idx++) begin
					if (shadow_map[MAP_AW'(idx)] == rq.owner[OWNER_WIDTH_DEF-1:0])
						shadow_map[MAP_AW'(idx)] = '0;
				end
				shadow_rt_end = '0;
				res.st = ST_FREED;
			end
		end
	endtask

	// present one request, wait for it to be taken, queue its expected result
	task automatic send_request(input request_t rq, input bit typed, input result_t typed_res,
			output result_t pred);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			burst_left = $urandom_range(1, 16);
		end
		burst_left--;
		in_valid       <= 1'b1;
		command        <= rq.cmd;
		realtime_class <= rq.rt;
		owner_id       <= rq.owner;
		start_block    <= rq.start;
		block_count    <= rq.count;
		@(posedge clk);
		while (in_stall) @(posedge clk);
		predict_map_update(rq, pred);
		pending_results.push_back(typed ? typed_res : pred);
	endtask

	task automatic add_row(input logic cmd, input logic rt, input int owner, input int start,
			input int count, input bit typed, input status_t st, input int cf);
		table_row_t row;
		row.rq.cmd = cmd;
		row.rq.rt = rt;
		row.rq.owner = owner[OWNER_IN_W-1:0];
		row.rq.start = start[START_W-1:0];
		row.rq.count = count[COUNT_W-1:0];
		row.typed = typed;
		row.res.st = st;
		row.res.cf = cf[CONFLICT_W-1:0];
		directed_reqs.push_back(row);
	endtask

	function automatic void note_failure(input string msg);
		fail_count++;
		if (fail_count <= REPORT_LIMIT)
			$display("%s", msg);
	endfunction

	// receiver stall pattern: short runs either way, now and then a long quiet stretch
	always @(posedge clk) begin
		int pick;
		if (stall_run == 0) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				out_stall <= 1'b0;
				stall_run <= 150;
			end else if (pick < 4) begin
				out_stall <= 1'b1;
				stall_run <= $urandom_range(1, 24);
			end else begin
				out_stall <= 1'b0;
				stall_run <= $urandom_range(1, 24);
			end
		end else begin
			stall_run <= stall_run - 1;
		end
	end

	// result checker
	always @(posedge clk) begin
		result_t exp_res;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				note_failure($sformatf("unexpected result: status %0d conflict %0d",
					status, conflict_block));
			end else begin
				exp_res = pending_results.pop_front();
				if (status !== exp_res.st || conflict_block !== exp_res.cf)
					note_failure($sformatf(
						"mismatch: expected status %0d conflict %0d, got status %0d conflict %0d",
						exp_res.st, exp_res.cf, status, conflict_block));
			end
		end
	end

	// run limit
	initial begin
		#30_000_000;
		$display("Test completed with failures");
		$finish;
	end

	// stimulus
	initial begin
		request_t rq;
		result_t  pred;
		result_t  none;
		int       kind;
		int       k;
		int       n;

		none.st = ST_ALLOCATED;
		none.cf = '0;
		shadow_rt_end = '0;
		shadow_user_end = '0;
		for (k = 0; k < MAP_SIZE; k++)
			shadow_map[MAP_AW'(k)] = '0;
		for (k = 0; k < 8; k++)
			owner_pool[3'(k)] = OWNER_IN_W'($urandom_range(1, 65535));

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed table: zero counts, real-time full, occupied, out of range, owner zero
		add_row(CMD_ALLOC, CLASS_USER, 1, 0, 0, 1, ST_ALLOCATED, 0);
		add_row(CMD_ALLOC, CLASS_RT, 16'hFFFF, 0, 64, 1, ST_ALLOCATED, 0);
		add_row(CMD_ALLOC, CLASS_RT, 5, 100, 1, 1, ST_FULL, 0);
		add_row(CMD_ALLOC, CLASS_USER, 7, 10, 5, 1, ST_OCCUPIED, 10);
		add_row(CMD_ALLOC, CLASS_USER, 7, 1023, 2, 1, ST_RANGE, 0);
		add_row(CMD_ALLOC, CLASS_USER, 7, 1023, 2047, 1, ST_RANGE, 0);
		add_row(CMD_FREE, CLASS_USER, 7, 1000, 100, 1, ST_RANGE, 0);
		add_row(CMD_ALLOC, CLASS_RT, 3, 200, 1, 1, ST_FULL, 0);
		add_row(CMD_FREE, CLASS_RT, 16'hFFFF, 0, 0, 1, ST_FREED, 0);
		add_row(CMD_ALLOC, CLASS_RT, 3, 60, 8, 1, ST_OCCUPIED, 60);
		add_row(CMD_FREE, CLASS_USER, 0, 0, 64, 1, ST_FREED, 0);
		add_row(CMD_ALLOC, CLASS_USER, 0, 500, 4, 1, ST_ALLOCATED, 0);
		add_row(CMD_ALLOC, CLASS_USER, 9, 500, 4, 1, ST_ALLOCATED, 0);
		add_row(CMD_ALLOC, CLASS_RT, 16'h1234, 900, 10, 0, ST_ALLOCATED, 0);
		add_row(CMD_ALLOC, CLASS_RT, 16'h1234, 64, 0, 1, ST_ALLOCATED, 0);
		add_row(CMD_ALLOC, CLASS_RT, 1, 0, 0, 1, ST_FULL, 0);
		add_row(CMD_FREE, CLASS_USER, 9, 500, 4, 1, ST_FREED, 0);
		add_row(CMD_ALLOC, CLASS_USER, 16'h8001, 500, 4, 0, ST_ALLOCATED, 0);
		add_row(CMD_FREE, CLASS_RT, 16'hFFFF, 0, 1024, 1, ST_FREED, 0);
		add_row(CMD_ALLOC, CLASS_USER, 16'h7FFE, 0, 64, 0, ST_ALLOCATED, 0);
		add_row(CMD_FREE, CLASS_USER, 16'h7FFE, 0, 64, 0, ST_ALLOCATED, 0);
		add_row(CMD_ALLOC, CLASS_RT, 16'hFFFF, 1023, 1, 0, ST_ALLOCATED, 0);
		add_row(CMD_ALLOC, CLASS_USER, 16'h0F0F, 1020, 3, 0, ST_ALLOCATED, 0);
		add_row(CMD_ALLOC, CLASS_USER, 5, 1022, 1, 1, ST_OCCUPIED, 1022);
		add_row(CMD_ALLOC, CLASS_RT, 5, 1023, 1, 1, ST_OCCUPIED, 1023);
		add_row(CMD_FREE, CLASS_RT, 16'h0F0F, 1020, 4, 0, ST_ALLOCATED, 0);

		foreach (directed_reqs[i])
			send_request(directed_reqs[i].rq, directed_reqs[i].typed, directed_reqs[i].res, pred);

		// random traffic, mostly allocate and release of spans with live owners
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			kind = $urandom_range(0, 99);
			rq.cmd = CMD_ALLOC;
			rq.rt = CLASS_USER;
			rq.owner = owner_pool[3'($urandom_range(0, 7))];
			if (kind < 40) begin
				if ($urandom_range(0, 2) == 0) begin
					rq.rt = CLASS_RT;
					rq.start = START_W'($urandom_range(0, 56));
					rq.count = COUNT_W'($urandom_range(1, 8));
				end else begin
					rq.start = START_W'($urandom_range(64, 1000));
					rq.count = COUNT_W'($urandom_range(1, 16));
				end
			end else if (kind < 65 && live_spans.size() != 0) begin
				k = $urandom_range(0, live_spans.size() - 1);
				rq = live_spans[k];
				live_spans.delete(k);
				rq.cmd = CMD_FREE;
				rq.rt = 1'($urandom_range(0, 1));
			end else if (kind < 75) begin
				rq.cmd = CMD_FREE;
				rq.rt = 1'($urandom_range(0, 1));
				if ($urandom_range(0, 7) == 0)
					rq.owner = '0;
				rq.start = START_W'($urandom_range(0, 1000));
				rq.count = COUNT_W'($urandom_range(0, 24));
			end else if (kind < 85) begin
				// span running past the end of the map
				rq.cmd = 1'($urandom_range(0, 1));
				rq.rt = 1'($urandom_range(0, 1));
				k = $urandom_range(1, 1023);
				rq.start = START_W'(k);
				rq.count = COUNT_W'($urandom_range(MAP_SIZE - k + 1, MAP_SIZE));
			end else if (kind < 92) begin
				k = $urandom_range(32, 128);
				rq.count = COUNT_W'(k);
				rq.start = START_W'($urandom_range(64, MAP_SIZE - k - 1));
			end else begin
				rq.cmd = 1'($urandom_range(0, 1));
				rq.rt = 1'($urandom_range(0, 1));
				rq.owner = OWNER_IN_W'($urandom_range(0, 65535));
				rq.start = START_W'($urandom_range(0, 1023));
				rq.count = COUNT_W'($urandom_range(0, 1024));
				// keep the user region open for the rest of the run
				if (rq.cmd == CMD_ALLOC && rq.rt == CLASS_USER
						&& int'(rq.start) + int'(rq.count) == MAP_SIZE)
					rq.count = rq.count - 1'b1;
			end
			send_request(rq, 1'b0, none, pred);
			if (rq.cmd == CMD_ALLOC && pred.st == ST_ALLOCATED && rq.count != '0
					&& rq.owner != '0)
				live_spans.push_back(rq);
		end

		// closing: fill the user region up to the end and check it stays full
		rq.rt = CLASS_USER;
		rq.start = START_W'(MAP_SIZE - 1);
		rq.count = COUNT_W'(1);
		rq.cmd = CMD_FREE;
		rq.owner = shadow_map[MAP_AW'(MAP_SIZE - 1)];
		send_request(rq, 1'b0, none, pred);
		rq.cmd = CMD_ALLOC;
		rq.owner = 16'h4321;
		send_request(rq, 1'b0, none, pred);
		rq.owner = 16'h0002;
		rq.start = START_W'(100);
		send_request(rq, 1'b0, none, pred);
		rq.cmd = CMD_FREE;
		rq.owner = 16'h4321;
		rq.start = START_W'(MAP_SIZE - 1);
		send_request(rq, 1'b0, none, pred);
		rq.cmd = CMD_ALLOC;
		rq.count = '0;
		send_request(rq, 1'b0, none, pred);

		in_valid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (100) @(posedge clk);
		if (fail_count == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
